@@ sv/tak_pkg.sv @@
// tilt angle kalman filter package: payload types, register indexes, reset values
// and fixed-point helpers (rounding of q8.24 products, saturation to 32 bits)
// no dependencies
package tak_pkg;

    typedef struct packed {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate_out;
        logic signed [31:0] rate_estimate_out;
    } out_item_t;

    localparam int CfgW = 31;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [1:0] REG_TIME_STEP   = 2'd3;

    localparam logic [CfgW-1:0] RST_ANGLE_NOISE = 31'd16777;
    localparam logic [CfgW-1:0] RST_BIAS_NOISE  = 31'd50332;
    localparam logic [CfgW-1:0] RST_MEAS_NOISE  = 31'd8388608;
    localparam logic [CfgW-1:0] RST_TIME_STEP   = 31'd83886;

    localparam logic signed [31:0] ONE_Q24  = 32'sd16777216;
    localparam logic signed [65:0] HALF_Q24 = 66'sd8388608;
    localparam logic signed [31:0] MAX_S32  = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_S32  = 32'sh80000000;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] res;
        if (v > 43'sd2147483647)
            res = MAX_S32;
        else if (v < -43'sd2147483648)
            res = MIN_S32;
        else
            res = v[31:0];
        return res;
    endfunction

    // round half up, then floor shift by 24
    function automatic logic signed [41:0] round_q24(input logic signed [65:0] p);
        logic signed [65:0] s;
        s = p + HALF_Q24;
        return signed'(s[65:24]);
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [31:0] a,
                                                   input logic signed [41:0] r,
                                                   input logic sub_op);
        logic signed [42:0] s;
        if (sub_op)
            s = 43'(a) - 43'(r);
        else
            s = 43'(a) + 43'(r);
        return sat32(s);
    endfunction

endpackage

@@ sv/tak_stream_if.sv @@
// valid/ready stream channel carrying one payload item per transfer
// payload type is a parameter, normally a struct from tak_pkg
interface tak_stream_if #(parameter type T = logic [63:0]) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tilt_angle_kalman_filter.sv @@
// two-state kalman filter (angle, gyro bias) on one shared 33x33 multiplier
// and a one-bit-per-cycle restoring divider; uses tak_pkg and tak_stream_if
// one input is processed at a time; the divider is skipped when the innovation
// variance is zero; the next input is taken the cycle after the result is loaded
// the divider runs once for each of the two gains
// reset: registers to defaults, angle and bias zero, covariance identity
module tilt_angle_kalman_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    tak_stream_if.sink   in_ch,
    tak_stream_if.source out_ch
);
    import tak_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PRE   = 5'd1;
    localparam logic [4:0] S_MANG  = 5'd2;
    localparam logic [4:0] S_MP00  = 5'd3;
    localparam logic [4:0] S_MP01  = 5'd4;
    localparam logic [4:0] S_MP10  = 5'd5;
    localparam logic [4:0] S_MP11  = 5'd6;
    localparam logic [4:0] S_GAIN  = 5'd7;
    localparam logic [4:0] S_DINIT = 5'd8;
    localparam logic [4:0] S_DIV   = 5'd9;
    localparam logic [4:0] S_U0    = 5'd10;
    localparam logic [4:0] S_U1    = 5'd11;
    localparam logic [4:0] S_U2    = 5'd12;
    localparam logic [4:0] S_U3    = 5'd13;
    localparam logic [4:0] S_U4    = 5'd14;
    localparam logic [4:0] S_U5    = 5'd15;
    localparam logic [4:0] S_U6    = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    // config and filter state
    logic [CfgW-1:0]    apn_reg, apn_next, bpn_reg, bpn_next;
    logic [CfgW-1:0]    mn_reg, mn_next, dt_reg, dt_next;
    logic [4:0]         state_reg, state_next;
    logic signed [31:0] angle_reg, angle_next, bias_reg, bias_next;
    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic               out_valid_reg, out_valid_next;

    // working registers
    logic signed [31:0] accel_reg, accel_next, gyro_reg, gyro_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [31:0] d0_reg, d0_next, d1_reg, d1_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [32:0] e_reg, e_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic [32:0]        rem_reg, rem_next, emag_reg, emag_next;
    logic [31:0]        sh_reg, sh_next, q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next, neg_reg, neg_next, dsel_reg, dsel_next;
    logic signed [65:0] prod_reg;
    logic signed [31:0] out_angle_reg, out_angle_next, out_rate_reg, out_rate_next;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_w;
    logic signed [41:0] rnd;
    logic signed [32:0] dt33;

    // divider datapath
    logic signed [31:0] num_w;
    logic [31:0]        nmag_w;
    logic [32:0]        emag_w;
    logic [33:0]        trial_w, tdiff_w;
    logic               ge_w;
    logic [31:0]        qnew_w;
    logic signed [31:0] kval_w;

    assign prod_w = mul_a * mul_b;
    assign rnd    = round_q24(prod_reg);
    assign dt33   = signed'({2'b00, dt_reg});

    assign num_w   = dsel_reg ? p_reg[2] : p_reg[0];
    assign nmag_w  = num_w[31] ? unsigned'(-num_w) : unsigned'(num_w);
    assign emag_w  = e_reg[32] ? unsigned'(-e_reg) : unsigned'(e_reg);
    assign trial_w = {rem_reg, sh_reg[31]};
    assign tdiff_w = trial_w - {1'b0, emag_reg};
    assign ge_w    = trial_w >= {1'b0, emag_reg};
    assign qnew_w  = {q_reg[30:0], ge_w};

    always_comb
    begin
        if (ovf_reg)
            kval_w = neg_reg ? MIN_S32 : MAX_S32;
        else if (neg_reg)
            kval_w = (qnew_w > 32'h80000000) ? MIN_S32 : signed'(-qnew_w);
        else
            kval_w = qnew_w[31] ? MAX_S32 : signed'(qnew_w);
    end

    assign in_ch.ready                    = (state_reg == S_IDLE);
    assign out_ch.valid                   = out_valid_reg;
    assign out_ch.data.angle_estimate_out = out_angle_reg;
    assign out_ch.data.rate_estimate_out  = out_rate_reg;

    always_comb
    begin
        apn_next       = apn_reg;
        bpn_next       = bpn_reg;
        mn_next        = mn_reg;
        dt_next        = dt_reg;
        state_next     = state_reg;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg;
        accel_next     = accel_reg;
        gyro_next      = gyro_reg;
        diff_next      = diff_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        err_next       = err_reg;
        e_next         = e_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        rem_next       = rem_reg;
        emag_next      = emag_reg;
        sh_next        = sh_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        dsel_next      = dsel_reg;
        out_angle_next = out_angle_reg;
        out_rate_next  = out_rate_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_NOISE: apn_next = cfg_wdata;
                REG_BIAS_NOISE:  bpn_next = cfg_wdata;
                REG_MEAS_NOISE:  mn_next  = cfg_wdata;
                REG_TIME_STEP:   dt_next  = cfg_wdata;
                default:         apn_next = apn_reg;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    accel_next = in_ch.data.accel_angle;
                    gyro_next  = in_ch.data.gyro_rate;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                diff_next  = 33'(gyro_reg) - 33'(bias_reg);
                d0_next    = sat32(43'(signed'({1'b0, apn_reg})) - 43'(p_reg[1])
                                   - 43'(p_reg[2]));
                d1_next    = sat32(-43'(p_reg[3]));
                state_next = S_MANG;
            end
            S_MANG:
            begin
                mul_a      = diff_reg;
                mul_b      = dt33;
                state_next = S_MP00;
            end
            S_MP00:
            begin
                mul_a      = 33'(d0_reg);
                mul_b      = dt33;
                angle_next = sat_acc(angle_reg, rnd, 1'b0);
                state_next = S_MP01;
            end
            S_MP01:
            begin
                mul_a      = 33'(d1_reg);
                mul_b      = dt33;
                p_next[0]  = sat_acc(p_reg[0], rnd, 1'b0);
                state_next = S_MP10;
            end
            S_MP10:
            begin
                mul_a      = 33'(d1_reg);
                mul_b      = dt33;
                p_next[1]  = sat_acc(p_reg[1], rnd, 1'b0);
                state_next = S_MP11;
            end
            S_MP11:
            begin
                mul_a      = signed'({2'b00, bpn_reg});
                mul_b      = dt33;
                p_next[2]  = sat_acc(p_reg[2], rnd, 1'b0);
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                p_next[3]  = sat_acc(p_reg[3], rnd, 1'b0);
                err_next   = sat32(43'(accel_reg) - 43'(angle_reg));
                e_next     = signed'({2'b00, mn_reg}) + 33'(p_reg[0]);
                dsel_next  = 1'b0;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                if (e_reg == 33'sd0)
                begin
                    k0_next    = '0;
                    k1_next    = '0;
                    state_next = S_U0;
                end
                else
                begin
                    emag_next  = emag_w;
                    rem_next   = {9'd0, nmag_w[31:8]};
                    sh_next    = {nmag_w[7:0], 24'd0};
                    ovf_next   = {9'd0, nmag_w[31:8]} >= emag_w;
                    neg_next   = num_w[31] ^ e_reg[32];
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = ge_w ? tdiff_w[32:0] : trial_w[32:0];
                sh_next  = {sh_reg[30:0], 1'b0};
                q_next   = qnew_w;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    if (!dsel_reg)
                    begin
                        k0_next    = kval_w;
                        dsel_next  = 1'b1;
                        state_next = S_DINIT;
                    end
                    else
                    begin
                        k1_next    = kval_w;
                        state_next = S_U0;
                    end
                end
            end
            S_U0:
            begin
                mul_a      = 33'(k0_reg);
                mul_b      = 33'(p_reg[0]);
                state_next = S_U1;
            end
            S_U1:
            begin
                mul_a      = 33'(k1_reg);
                mul_b      = 33'(p_reg[0]);
                p_next[0]  = sat_acc(p_reg[0], rnd, 1'b1);
                state_next = S_U2;
            end
            S_U2:
            begin
                mul_a      = 33'(k0_reg);
                mul_b      = 33'(p_reg[1]);
                p_next[2]  = sat_acc(p_reg[2], rnd, 1'b1);
                state_next = S_U3;
            end
            S_U3:
            begin
                mul_a      = 33'(k1_reg);
                mul_b      = 33'(p_reg[1]);
                p_next[1]  = sat_acc(p_reg[1], rnd, 1'b1);
                state_next = S_U4;
            end
            S_U4:
            begin
                mul_a      = 33'(k0_reg);
                mul_b      = 33'(err_reg);
                p_next[3]  = sat_acc(p_reg[3], rnd, 1'b1);
                state_next = S_U5;
            end
            S_U5:
            begin
                mul_a      = 33'(k1_reg);
                mul_b      = 33'(err_reg);
                angle_next = sat_acc(angle_reg, rnd, 1'b0);
                state_next = S_U6;
            end
            S_U6:
            begin
                bias_next  = sat_acc(bias_reg, rnd, 1'b0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_angle_next = angle_reg;
                    out_rate_next  = sat32(43'(gyro_reg) - 43'(bias_reg));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apn_reg       <= RST_ANGLE_NOISE;
            bpn_reg       <= RST_BIAS_NOISE;
            mn_reg        <= RST_MEAS_NOISE;
            dt_reg        <= RST_TIME_STEP;
            state_reg     <= S_IDLE;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p_reg[0]      <= ONE_Q24;
            p_reg[1]      <= '0;
            p_reg[2]      <= '0;
            p_reg[3]      <= ONE_Q24;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            apn_reg       <= apn_next;
            bpn_reg       <= bpn_next;
            mn_reg        <= mn_next;
            dt_reg        <= dt_next;
            state_reg     <= state_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accel_reg     <= accel_next;
        gyro_reg      <= gyro_next;
        diff_reg      <= diff_next;
        d0_reg        <= d0_next;
        d1_reg        <= d1_next;
        err_reg       <= err_next;
        e_reg         <= e_next;
        k0_reg        <= k0_next;
        k1_reg        <= k1_next;
        rem_reg       <= rem_next;
        emag_reg      <= emag_next;
        sh_reg        <= sh_next;
        q_reg         <= q_next;
        cnt_reg       <= cnt_next;
        ovf_reg       <= ovf_next;
        neg_reg       <= neg_next;
        dsel_reg      <= dsel_next;
        prod_reg      <= prod_w;
        out_angle_reg <= out_angle_next;
        out_rate_reg  <= out_rate_next;
    end

endmodule
